// ----- rtl/ars_pkg.sv -----
// Shared types, codes and helpers for the adaptive reading smoother.
package ars_pkg;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_CURRENT    = 2'd0,
    MODE_VOLTAGE    = 2'd1,
    MODE_RESISTANCE = 2'd2,
    MODE_OTHER      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    RANGE_NANO   = 3'd0,
    RANGE_MICRO  = 3'd1,
    RANGE_MILLI  = 3'd2,
    RANGE_UNIT   = 3'd3,
    RANGE_UNIT30 = 3'd4,
    RANGE_KILO   = 3'd5,
    RANGE_MEGA   = 3'd6
  } range_t;

  typedef enum logic [1:0] {
    CFG_COEFF = 2'd0,
    CFG_WAIT  = 2'd1,
    CFG_BAND  = 2'd2
  } cfg_idx_t;

  localparam logic [15:0] COEFF_RST = 16'd429;
  localparam logic [15:0] WAIT_RST  = 16'd1000;
  localparam logic [15:0] BAND_RST  = 16'd66;

  typedef struct packed {
    logic [15:0] coeff;
    logic [15:0] wait_ticks;
    logic [15:0] settle_band;
  } cfg_t;

  // |diff| > t * 2^32, with diff = hi * 2^32 + lo and lo unsigned
  function automatic logic beyond(logic signed [32:0] hi, logic [31:0] lo,
                                  logic signed [33:0] t);
    logic signed [33:0] hx;
    hx = {hi[32], hi};
    return (hx > t) || ((hx == t) && (lo != 32'd0)) || (hx < -t);
  endfunction

endpackage

// ----- rtl/ars_cfg_regs.sv -----
// Configuration register file for the adaptive reading smoother.
module ars_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output ars_pkg::cfg_t cfg
);
  import ars_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coeff       <= COEFF_RST;
      cfg_r.wait_ticks  <= WAIT_RST;
      cfg_r.settle_band <= BAND_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEFF: cfg_r.coeff       <= cfg_data;
        CFG_WAIT:  cfg_r.wait_ticks  <= cfg_data;
        CFG_BAND:  cfg_r.settle_band <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/ars_step.sv -----
// One-item update of the average, mode and wait counter.
module ars_step #(
  parameter int FRAC_BITS     = 16,
  parameter int COUNTER_WIDTH = 16
) (
  input  logic                     opcode,
  input  logic signed [31:0]       reading,
  input  logic [1:0]               meas_mode,
  input  logic [2:0]               range_code,
  input  ars_pkg::cfg_t            cfg,
  input  logic signed [63:0]       acc,
  input  logic [1:0]               prev_mode,
  input  logic [COUNTER_WIDTH-1:0] cnt,
  input  logic                     counting,
  output logic                     is_sample,
  output logic signed [63:0]       acc_nxt,
  output logic [1:0]               prev_mode_nxt,
  output logic [COUNTER_WIDTH-1:0] cnt_nxt,
  output logic                     counting_nxt
);
  import ars_pkg::*;

  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic signed [33:0] THR_TENTH   = 34'((ONE_Q + 5) / 10);
  localparam logic signed [33:0] THR_ONE     = 34'(ONE_Q);
  localparam logic signed [33:0] THR_TEN     = 34'(10 * ONE_Q);
  localparam logic signed [33:0] THR_FIFTY   = 34'(50 * ONE_Q);
  localparam logic signed [33:0] THR_HUNDRED = 34'(100 * ONE_Q);
  localparam int CMP_W = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;

  logic signed [64:0] diff;
  logic signed [33:0] thr;
  logic               has_thr;
  logic               jump;
  logic               mode_chg;
  logic               load;
  logic               settle;
  logic signed [81:0] prod;
  logic signed [63:0] delta;
  logic signed [63:0] loaded;

  assign is_sample = (opcode_t'(opcode) == OP_SAMPLE);
  assign loaded    = {reading, 32'd0};
  assign diff      = {reading[31], reading, 32'd0} - {acc[63], acc};

  always_comb begin
    has_thr = 1'b1;
    thr     = THR_TEN;
    case (mode_t'(meas_mode))
      MODE_CURRENT: thr = THR_TEN;
      MODE_VOLTAGE: begin
        case (range_t'(range_code))
          RANGE_MILLI:  thr = THR_FIFTY;
          RANGE_UNIT:   thr = THR_TENTH;
          RANGE_UNIT30: thr = THR_ONE;
          default:      has_thr = 1'b0;
        endcase
      end
      MODE_RESISTANCE: begin
        case (range_t'(range_code))
          RANGE_UNIT: thr = THR_ONE;
          RANGE_KILO: thr = THR_TEN;
          RANGE_MEGA: thr = THR_HUNDRED;
          default:    has_thr = 1'b0;
        endcase
      end
      default: has_thr = 1'b0;
    endcase
  end

  assign jump     = has_thr && beyond(diff[64:32], diff[31:0], thr);
  assign mode_chg = (meas_mode != prev_mode);
  assign load     = jump || mode_chg || (mode_t'(meas_mode) == MODE_OTHER) ||
                    (CMP_W'(cnt) < CMP_W'(cfg.wait_ticks));
  assign settle   = beyond(diff[64:32], diff[31:0], {18'd0, cfg.settle_band});
  // floor(coeff * diff / 2^32)
  assign prod     = 82'(diff) * 82'($signed({1'b0, cfg.coeff}));
  assign delta    = {{14{prod[81]}}, prod[81:32]};

  always_comb begin
    acc_nxt       = acc;
    prev_mode_nxt = prev_mode;
    cnt_nxt       = cnt;
    counting_nxt  = counting;
    if (!is_sample) begin
      if (counting && (cnt != '1)) begin
        cnt_nxt = cnt + COUNTER_WIDTH'(1);
      end
    end else begin
      prev_mode_nxt = meas_mode;
      if (jump || mode_chg) begin
        cnt_nxt      = '0;
        counting_nxt = 1'b1;
      end
      if (load) begin
        acc_nxt = loaded;
      end else if (settle) begin
        counting_nxt = 1'b0;
        acc_nxt      = acc + delta;
      end
    end
  end

endmodule

// ----- rtl/adaptive_reading_smoother.sv -----
// Top level of the adaptive reading smoother.
// Takes one item per cycle when not stalled. An item is captured in an input
// register; from there a single pass (jump check, one 17x65 multiply, add)
// updates the average and the wait counter and loads the result register, which
// holds a sample's result until it is taken. Sample items give one result, tick
// items none. The input register stalls only when a sample meets a result
// register still holding an untaken result. Configuration writes complete at
// once and are meant for idle periods.
module adaptive_reading_smoother #(
  parameter int FRAC_BITS     = 16,
  parameter int COUNTER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_reading,
  input  logic [1:0]         in_meas_mode,
  input  logic [2:0]         in_range_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_smoothed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import ars_pkg::*;

  cfg_t cfg;

  logic                     in_valid_r;
  logic                     opcode_r;
  logic signed [31:0]       reading_r;
  logic [1:0]               mode_r;
  logic [2:0]               range_r;

  logic signed [63:0]       acc_r;
  logic [1:0]               prev_mode_r;
  logic [COUNTER_WIDTH-1:0] cnt_r;
  logic                     counting_r;
  logic                     out_valid_r;
  logic signed [31:0]       smoothed_r;

  logic                     is_sample;
  logic signed [63:0]       acc_nxt;
  logic [1:0]               prev_mode_nxt;
  logic [COUNTER_WIDTH-1:0] cnt_nxt;
  logic                     counting_nxt;
  logic                     advance;

  ars_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ars_step #(
    .FRAC_BITS     (FRAC_BITS),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_step (
    .opcode        (opcode_r),
    .reading       (reading_r),
    .meas_mode     (mode_r),
    .range_code    (range_r),
    .cfg           (cfg),
    .acc           (acc_r),
    .prev_mode     (prev_mode_r),
    .cnt           (cnt_r),
    .counting      (counting_r),
    .is_sample     (is_sample),
    .acc_nxt       (acc_nxt),
    .prev_mode_nxt (prev_mode_nxt),
    .cnt_nxt       (cnt_nxt),
    .counting_nxt  (counting_nxt)
  );

  assign advance      = in_valid_r && (!is_sample || !out_valid_r || out_ready);
  assign in_ready     = !in_valid_r || advance;
  assign out_valid    = out_valid_r;
  assign out_smoothed = smoothed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      prev_mode_r <= MODE_CURRENT;
      cnt_r       <= '0;
      counting_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= (advance && is_sample) || (out_valid_r && !out_ready);
      if (advance) begin
        acc_r       <= acc_nxt;
        prev_mode_r <= prev_mode_nxt;
        cnt_r       <= cnt_nxt;
        counting_r  <= counting_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r  <= in_opcode;
      reading_r <= in_reading;
      mode_r    <= in_meas_mode;
      range_r   <= in_range_code;
    end
    if (advance && is_sample) begin
      smoothed_r <= acc_nxt[63:32];
    end
  end

endmodule

// ----- rtl/ars_checker.sv -----
// Port-level assertions for the adaptive reading smoother, bound to the top.
module ars_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_smoothed
);

  // input side backs up only behind an untaken result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a pending result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_smoothed)))
    else $error("pending result dropped or changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind adaptive_reading_smoother ars_checker u_ars_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_smoothed (out_smoothed)
);
